### rtl/stt_pkg.sv
// Shared types, constants and helper functions for the source text tokenizer.
package stt_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LINE_BITS   = 20;
	localparam int KW_MAX_LEN  = 8;
	localparam int MAX_RES     = 4;
	localparam int KW_COUNT    = 23;

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;

	// token kinds
	localparam logic [5:0] K_LPAREN      = 6'd23;
	localparam logic [5:0] K_RPAREN      = 6'd24;
	localparam logic [5:0] K_LBRACE      = 6'd25;
	localparam logic [5:0] K_RBRACE      = 6'd26;
	localparam logic [5:0] K_COLON       = 6'd27;
	localparam logic [5:0] K_SEMI        = 6'd28;
	localparam logic [5:0] K_COMMA       = 6'd29;
	localparam logic [5:0] K_PLUS_EQ     = 6'd30;
	localparam logic [5:0] K_PLUS_PLUS   = 6'd31;
	localparam logic [5:0] K_PLUS        = 6'd32;
	localparam logic [5:0] K_ARROW       = 6'd33;
	localparam logic [5:0] K_MINUS_EQ    = 6'd34;
	localparam logic [5:0] K_MINUS_MINUS = 6'd35;
	localparam logic [5:0] K_MINUS       = 6'd36;
	localparam logic [5:0] K_STAR_EQ     = 6'd37;
	localparam logic [5:0] K_STAR        = 6'd38;
	localparam logic [5:0] K_SLASH_EQ    = 6'd39;
	localparam logic [5:0] K_SLASH       = 6'd40;
	localparam logic [5:0] K_EQ_EQ       = 6'd41;
	localparam logic [5:0] K_EQ          = 6'd42;
	localparam logic [5:0] K_STRING      = 6'd43;
	localparam logic [5:0] K_CHAR        = 6'd44;
	localparam logic [5:0] K_RANGE       = 6'd45;
	localparam logic [5:0] K_DOT         = 6'd46;
	localparam logic [5:0] K_INT         = 6'd47;
	localparam logic [5:0] K_FLOAT       = 6'd48;
	localparam logic [5:0] K_IDENT       = 6'd49;
	localparam logic [5:0] K_EOF         = 6'd50;
	localparam logic [5:0] K_ERROR       = 6'd51;
	localparam logic [5:0] K_BALIK       = 6'd5;
	localparam logic [5:0] K_BUAK        = 6'd11;
	localparam logic [5:0] K_PADAYON     = 6'd12;

	// error codes
	localparam logic [2:0] E_NONE       = 3'd0;
	localparam logic [2:0] E_OPEN_STR   = 3'd1;
	localparam logic [2:0] E_OPEN_CHAR  = 3'd2;
	localparam logic [2:0] E_OPEN_ESC   = 3'd3;
	localparam logic [2:0] E_BAD_ESC    = 3'd4;
	localparam logic [2:0] E_NOT_SINGLE = 3'd5;
	localparam logic [2:0] E_UNEXPECTED = 3'd6;

	// special characters
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_NUM_DOT, M_FRACTION, M_PLUS, M_MINUS, M_STAR,
		M_SLASH, M_EQUAL, M_DOT, M_COMMENT, M_STRING, M_CHAR_OPEN, M_CHAR_ESC,
		M_CHAR_CLOSE
	} scan_mode_t;

	typedef struct packed {
		logic [5:0]             kind;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] span;
		logic [LINE_BITS-1:0]   line;
		logic [7:0]             lit;
		logic [2:0]             err;
	} token_t;

	typedef struct packed {
		scan_mode_t             mode;
		logic [OFFSET_BITS-1:0] token_start;
		logic [OFFSET_BITS-1:0] byte_offset;
		logic [OFFSET_BITS-1:0] dot_pos;
		logic [LINE_BITS-1:0]   line;
		logic [3:0]             word_len;
		logic [5:0]             last_kind;
		logic                   seen;
		logic [7:0]             pending;
	} scan_state_t;

	localparam scan_state_t STATE_RESET = '{
		mode: M_IDLE, token_start: '0, byte_offset: '0, dot_pos: '0,
		line: LINE_BITS'(1), word_len: '0, last_kind: '0, seen: 1'b0, pending: '0
	};

	// keyword text right-justified, first character in the highest used byte
	localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
		"ila", "numero", "doble", "letra", "tugoti", "balik", "samtang", "para",
		"kung", "kungdili", "kay", "buak", "padayon", "ug", "oh", "di", "tinuod",
		"peke", "sa", "buhata", "iprint", "xerox", "klase"
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd6, 4'd5, 4'd5, 4'd6, 4'd5, 4'd7, 4'd4, 4'd4, 4'd8, 4'd3, 4'd4,
		4'd7, 4'd2, 4'd2, 4'd2, 4'd6, 4'd4, 4'd2, 4'd6, 4'd6, 4'd5, 4'd5
	};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == CH_UNDER;
	endfunction

	function automatic logic qualifies(input logic [5:0] k);
		return k == K_STRING || k == K_INT || k == K_CHAR || k == K_FLOAT ||
			k == K_IDENT || k == K_PLUS_PLUS || k == K_MINUS_MINUS ||
			k == K_BUAK || k == K_PADAYON || k == K_BALIK;
	endfunction

	function automatic logic [5:0] word_kind(input logic [KW_MAX_LEN-1:0][7:0] wp,
			input logic [3:0] len);
		logic [5:0] k;
		logic       hit;
		logic [7:0] kc;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			hit = (KW_LEN[i] == len);
			for (int j = 0; j < KW_MAX_LEN; j++) begin
				kc = KW_TEXT[i][8*((KW_MAX_LEN-1-j) % KW_MAX_LEN) +: 8];
				if (j < int'(KW_LEN[i])) begin
					kc = KW_TEXT[i][8*((int'(KW_LEN[i])-1-j) % KW_MAX_LEN) +: 8];
					if (wp[j] != kc) hit = 1'b0;
				end
			end
			if (hit) k = 6'(i);
		end
		return k;
	endfunction

endpackage

### rtl/stt_in_if.sv
// Source byte channel: valid/ready with one byte and end marker per transfer.
interface stt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       has_char;
	logic       end_of_source;

	modport source (output valid, char_byte, has_char, end_of_source, input ready);
	modport sink (input valid, char_byte, has_char, end_of_source, output ready);
endinterface

### rtl/stt_out_if.sv
// Token channel: valid/ready with one token per transfer.
interface stt_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [23:0] start_offset;
	logic [23:0] span_length;
	logic [19:0] line_number;
	logic [7:0]  literal_char;
	logic [2:0]  error_code;
	logic        last_of_run;

	modport source (output valid, token_kind, start_offset, span_length, line_number,
		literal_char, error_code, last_of_run, input ready);
	modport sink (input valid, token_kind, start_offset, span_length, line_number,
		literal_char, error_code, last_of_run, output ready);
endinterface

### rtl/stt_scan.sv
// Scanner state registers and the per-byte next-state and token logic.
module stt_scan (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 take,
	input  logic [7:0]                           char_byte,
	input  logic                                 has_char,
	input  logic                                 end_of_source,
	output stt_pkg::token_t [stt_pkg::MAX_RES-1:0] toks,
	output logic [2:0]                           count
);
	import stt_pkg::*;

	scan_state_t                    st_q;
	scan_state_t                    st_d;
	logic [KW_MAX_LEN-1:0][7:0]     word_prefix_q;
	logic [KW_MAX_LEN-1:0][7:0]     wp;

	function automatic void push(inout token_t [MAX_RES-1:0] tk, inout logic [2:0] n,
			inout logic [5:0] lk, inout logic seen, input logic [5:0] kind,
			input logic [OFFSET_BITS-1:0] s, input logic [OFFSET_BITS:0] e,
			input logic [7:0] lit, input logic [2:0] err, input logic [LINE_BITS-1:0] ln);
		logic [OFFSET_BITS:0] d;
		token_t               t;
		d = e - {1'b0, s};
		t.kind  = kind;
		t.start = s;
		t.span  = (e > {1'b0, s}) ? (d[OFFSET_BITS] ? OFFSET_MAX : d[OFFSET_BITS-1:0]) : '0;
		t.line  = ln;
		t.lit   = lit;
		t.err   = err;
		if (n < 3'(MAX_RES)) begin
			tk[n[1:0]] = t;
			n = n + 3'd1;
			if (kind != K_ERROR) begin
				lk   = kind;
				seen = 1'b1;
			end
		end
	endfunction

	always_comb begin
		scan_state_t          s;
		logic                 rescan;
		logic [8:0]           v;
		logic [7:0]           c;
		logic [OFFSET_BITS:0] p1;
		logic [OFFSET_BITS:0] ts1;
		logic [OFFSET_BITS:0] dp0;
		logic [OFFSET_BITS:0] dp1;
		token_t [MAX_RES-1:0] tk;
		logic [2:0]           n;
		s      = st_q;
		wp     = word_prefix_q;
		c      = char_byte;
		tk     = '0;
		n      = '0;
		rescan = 1'b0;
		v      = '0;
		p1     = {1'b0, s.byte_offset} + 1'b1;
		ts1    = {1'b0, s.token_start} + 1'b1;
		dp0    = {1'b0, s.dot_pos};
		dp1    = {1'b0, s.dot_pos} + 1'b1;
		if (has_char) begin
			unique case (s.mode)
				M_IDLE: rescan = 1'b1;
				M_IDENT: begin
					if (is_word(c)) begin
						if (s.word_len < 4'(KW_MAX_LEN)) wp[s.word_len[2:0]] = c;
						if (s.word_len <= 4'(KW_MAX_LEN)) s.word_len = s.word_len + 4'd1;
					end else begin
						push(tk, n, s.last_kind, s.seen, word_kind(wp, s.word_len),
							s.token_start, {1'b0, s.byte_offset}, '0, E_NONE, s.line);
						rescan = 1'b1;
					end
				end
				M_NUMBER: begin
					if (c == ".") begin
						s.dot_pos = s.byte_offset;
						s.mode    = M_NUM_DOT;
					end else if (!(is_digit(c) || c == CH_UNDER)) begin
						push(tk, n, s.last_kind, s.seen, K_INT, s.token_start,
							{1'b0, s.byte_offset}, '0, E_NONE, s.line);
						rescan = 1'b1;
					end
				end
				M_NUM_DOT: begin
					if (is_digit(c)) begin
						s.mode = M_FRACTION;
					end else begin
						push(tk, n, s.last_kind, s.seen, K_INT, s.token_start, dp0, '0,
							E_NONE, s.line);
						if (c == ".") begin
							push(tk, n, s.last_kind, s.seen, K_RANGE, s.dot_pos, p1, '0,
								E_NONE, s.line);
							s.mode = M_IDLE;
						end else begin
							push(tk, n, s.last_kind, s.seen, K_DOT, s.dot_pos, dp1, '0,
								E_NONE, s.line);
							rescan = 1'b1;
						end
					end
				end
				M_FRACTION: begin
					if (!(is_digit(c) || c == CH_UNDER)) begin
						push(tk, n, s.last_kind, s.seen, K_FLOAT, s.token_start,
							{1'b0, s.byte_offset}, '0, E_NONE, s.line);
						rescan = 1'b1;
					end
				end
				M_PLUS: begin
					if (c == "=") push(tk, n, s.last_kind, s.seen, K_PLUS_EQ, s.token_start,
						p1, '0, E_NONE, s.line);
					else if (c == "+") push(tk, n, s.last_kind, s.seen, K_PLUS_PLUS,
						s.token_start, p1, '0, E_NONE, s.line);
					else begin
						push(tk, n, s.last_kind, s.seen, K_PLUS, s.token_start, ts1, '0,
							E_NONE, s.line);
						rescan = 1'b1;
					end
					s.mode = M_IDLE;
				end
				M_MINUS: begin
					if (c == ">") push(tk, n, s.last_kind, s.seen, K_ARROW, s.token_start,
						p1, '0, E_NONE, s.line);
					else if (c == "=") push(tk, n, s.last_kind, s.seen, K_MINUS_EQ,
						s.token_start, p1, '0, E_NONE, s.line);
					else if (c == "-") push(tk, n, s.last_kind, s.seen, K_MINUS_MINUS,
						s.token_start, p1, '0, E_NONE, s.line);
					else begin
						push(tk, n, s.last_kind, s.seen, K_MINUS, s.token_start, ts1, '0,
							E_NONE, s.line);
						rescan = 1'b1;
					end
					s.mode = M_IDLE;
				end
				M_STAR: begin
					if (c == "=") push(tk, n, s.last_kind, s.seen, K_STAR_EQ, s.token_start,
						p1, '0, E_NONE, s.line);
					else begin
						push(tk, n, s.last_kind, s.seen, K_STAR, s.token_start, ts1, '0,
							E_NONE, s.line);
						rescan = 1'b1;
					end
					s.mode = M_IDLE;
				end
				M_SLASH: begin
					s.mode = M_IDLE;
					if (c == "=") push(tk, n, s.last_kind, s.seen, K_SLASH_EQ,
						s.token_start, p1, '0, E_NONE, s.line);
					else if (c == "/") s.mode = M_COMMENT;
					else begin
						push(tk, n, s.last_kind, s.seen, K_SLASH, s.token_start, ts1, '0,
							E_NONE, s.line);
						rescan = 1'b1;
					end
				end
				M_EQUAL: begin
					if (c == "=") push(tk, n, s.last_kind, s.seen, K_EQ_EQ, s.token_start,
						p1, '0, E_NONE, s.line);
					else begin
						push(tk, n, s.last_kind, s.seen, K_EQ, s.token_start, ts1, '0,
							E_NONE, s.line);
						rescan = 1'b1;
					end
					s.mode = M_IDLE;
				end
				M_DOT: begin
					if (c == ".") push(tk, n, s.last_kind, s.seen, K_RANGE, s.token_start,
						p1, '0, E_NONE, s.line);
					else begin
						push(tk, n, s.last_kind, s.seen, K_DOT, s.token_start, ts1, '0,
							E_NONE, s.line);
						rescan = 1'b1;
					end
					s.mode = M_IDLE;
				end
				M_COMMENT: if (c == CH_NL) rescan = 1'b1;
				M_STRING: begin
					if (c == CH_DQUOTE) begin
						push(tk, n, s.last_kind, s.seen, K_STRING, s.token_start, p1, '0,
							E_NONE, s.line);
						s.mode = M_IDLE;
					end
				end
				M_CHAR_OPEN: begin
					if (c == CH_BSLASH) s.mode = M_CHAR_ESC;
					else begin
						s.pending = c;
						s.mode    = M_CHAR_CLOSE;
					end
				end
				M_CHAR_ESC: begin
					unique case (c)
						"n":       v = {1'b0, CH_NL};
						"t":       v = {1'b0, CH_TAB};
						"r":       v = {1'b0, CH_CR};
						CH_BSLASH: v = {1'b0, CH_BSLASH};
						CH_SQUOTE: v = {1'b0, CH_SQUOTE};
						"0":       v = 9'd0;
						default:   v = 9'h100;
					endcase
					if (v[8]) begin
						push(tk, n, s.last_kind, s.seen, K_ERROR, s.token_start, p1, '0,
							E_BAD_ESC, s.line);
						s.mode = M_IDLE;
					end else begin
						s.pending = v[7:0];
						s.mode    = M_CHAR_CLOSE;
					end
				end
				M_CHAR_CLOSE: begin
					if (c == CH_SQUOTE) begin
						push(tk, n, s.last_kind, s.seen, K_CHAR, s.token_start, p1,
							s.pending, E_NONE, s.line);
						s.mode = M_IDLE;
					end else begin
						push(tk, n, s.last_kind, s.seen, K_ERROR, s.token_start,
							{1'b0, s.byte_offset}, '0, E_NOT_SINGLE, s.line);
						rescan = 1'b1;
					end
				end
			endcase

			// start of a new token at this byte
			if (rescan) begin
				s.token_start = s.byte_offset;
				s.mode        = M_IDLE;
				unique case (c)
					"(": push(tk, n, s.last_kind, s.seen, K_LPAREN, s.byte_offset, p1, '0,
						E_NONE, s.line);
					")": push(tk, n, s.last_kind, s.seen, K_RPAREN, s.byte_offset, p1, '0,
						E_NONE, s.line);
					"{": push(tk, n, s.last_kind, s.seen, K_LBRACE, s.byte_offset, p1, '0,
						E_NONE, s.line);
					"}": push(tk, n, s.last_kind, s.seen, K_RBRACE, s.byte_offset, p1, '0,
						E_NONE, s.line);
					":": push(tk, n, s.last_kind, s.seen, K_COLON, s.byte_offset, p1, '0,
						E_NONE, s.line);
					";": push(tk, n, s.last_kind, s.seen, K_SEMI, s.byte_offset, p1, '0,
						E_NONE, s.line);
					",": push(tk, n, s.last_kind, s.seen, K_COMMA, s.byte_offset, p1, '0,
						E_NONE, s.line);
					"+": s.mode = M_PLUS;
					"-": s.mode = M_MINUS;
					"*": s.mode = M_STAR;
					"/": s.mode = M_SLASH;
					"=": s.mode = M_EQUAL;
					".": s.mode = M_DOT;
					CH_DQUOTE: s.mode = M_STRING;
					CH_SQUOTE: s.mode = M_CHAR_OPEN;
					" ", CH_CR, CH_TAB: ;
					CH_NL: begin
						if (s.line != LINE_MAX) s.line = s.line + 1'b1;
						if (s.seen && qualifies(s.last_kind))
							push(tk, n, s.last_kind, s.seen, K_SEMI, s.byte_offset, p1, '0,
								E_NONE, s.line);
					end
					default: begin
						if (is_digit(c)) begin
							s.mode = M_NUMBER;
						end else if (is_alpha(c) || c == CH_UNDER) begin
							s.mode     = M_IDENT;
							wp[0]      = c;
							s.word_len = 4'd1;
						end else begin
							push(tk, n, s.last_kind, s.seen, K_ERROR, s.byte_offset, p1, '0,
								E_UNEXPECTED, s.line);
						end
					end
				endcase
			end
			if (s.byte_offset != OFFSET_MAX) s.byte_offset = s.byte_offset + 1'b1;
		end

		// flush the open token, then EOF, then back to the reset state
		if (end_of_source) begin
			ts1 = {1'b0, s.token_start} + 1'b1;
			dp0 = {1'b0, s.dot_pos};
			dp1 = {1'b0, s.dot_pos} + 1'b1;
			unique case (s.mode)
				M_IDENT: push(tk, n, s.last_kind, s.seen, word_kind(wp, s.word_len),
					s.token_start, {1'b0, s.byte_offset}, '0, E_NONE, s.line);
				M_NUMBER: push(tk, n, s.last_kind, s.seen, K_INT, s.token_start,
					{1'b0, s.byte_offset}, '0, E_NONE, s.line);
				M_NUM_DOT: begin
					push(tk, n, s.last_kind, s.seen, K_INT, s.token_start, dp0, '0,
						E_NONE, s.line);
					push(tk, n, s.last_kind, s.seen, K_DOT, s.dot_pos, dp1, '0,
						E_NONE, s.line);
				end
				M_FRACTION: push(tk, n, s.last_kind, s.seen, K_FLOAT, s.token_start,
					{1'b0, s.byte_offset}, '0, E_NONE, s.line);
				M_PLUS: push(tk, n, s.last_kind, s.seen, K_PLUS, s.token_start, ts1, '0,
					E_NONE, s.line);
				M_MINUS: push(tk, n, s.last_kind, s.seen, K_MINUS, s.token_start, ts1, '0,
					E_NONE, s.line);
				M_STAR: push(tk, n, s.last_kind, s.seen, K_STAR, s.token_start, ts1, '0,
					E_NONE, s.line);
				M_SLASH: push(tk, n, s.last_kind, s.seen, K_SLASH, s.token_start, ts1, '0,
					E_NONE, s.line);
				M_EQUAL: push(tk, n, s.last_kind, s.seen, K_EQ, s.token_start, ts1, '0,
					E_NONE, s.line);
				M_DOT: push(tk, n, s.last_kind, s.seen, K_DOT, s.token_start, ts1, '0,
					E_NONE, s.line);
				M_STRING: push(tk, n, s.last_kind, s.seen, K_ERROR, s.token_start,
					{1'b0, s.byte_offset}, '0, E_OPEN_STR, s.line);
				M_CHAR_OPEN: push(tk, n, s.last_kind, s.seen, K_ERROR, s.token_start,
					{1'b0, s.byte_offset}, '0, E_OPEN_CHAR, s.line);
				M_CHAR_ESC: push(tk, n, s.last_kind, s.seen, K_ERROR, s.token_start,
					{1'b0, s.byte_offset}, '0, E_OPEN_ESC, s.line);
				M_CHAR_CLOSE: push(tk, n, s.last_kind, s.seen, K_ERROR, s.token_start,
					{1'b0, s.byte_offset}, '0, E_NOT_SINGLE, s.line);
				M_IDLE, M_COMMENT: ;
			endcase
			push(tk, n, s.last_kind, s.seen, K_EOF, s.byte_offset, {1'b0, s.byte_offset},
				'0, E_NONE, s.line);
			s = STATE_RESET;
		end
		st_d  = s;
		toks  = tk;
		count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (take) begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_prefix_q <= wp;
		end
	end

endmodule

### rtl/stt_out.sv
// Result register: holds the tokens of one byte and hands them out one per transfer.
module stt_out (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  stt_pkg::token_t [stt_pkg::MAX_RES-1:0] toks,
	input  logic [2:0]                           count,
	output logic                                 free,
	stt_out_if.source                            tok
);
	import stt_pkg::*;

	token_t [MAX_RES-1:0] toks_q;
	logic [2:0]           cnt_q;
	logic [1:0]           idx_q;
	logic                 valid_q;
	logic                 last;
	token_t               cur;

	assign cur  = toks_q[idx_q];
	assign last = ({1'b0, idx_q} + 3'd1) == cnt_q;
	// next byte may enter while the final token of this one is taken
	assign free = !valid_q || (tok.ready && last);

	assign tok.valid        = valid_q;
	assign tok.token_kind   = cur.kind;
	assign tok.start_offset = cur.start;
	assign tok.span_length  = cur.span;
	assign tok.line_number  = cur.line;
	assign tok.literal_char = cur.lit;
	assign tok.error_code   = cur.err;
	assign tok.last_of_run  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else if (load && count != 3'd0) begin
			valid_q <= 1'b1;
			cnt_q   <= count;
			idx_q   <= '0;
		end else if (valid_q && tok.ready) begin
			if (last) valid_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && count != 3'd0) begin
			toks_q <= toks;
		end
	end

endmodule

### rtl/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
//
//  channel | dir | payload                                              | per transfer
//  src     | in  | char_byte, has_char, end_of_source                   | one source byte
//  tok     | out | token_kind .. error_code, last_of_run                | one token
//
// A byte is scanned in the cycle it is accepted; its tokens (0 to 4) sit in a result
// register and leave one per cycle while tok.ready is high, so one byte per cycle is
// sustained while each byte yields at most one token and tok.ready stays high. A byte
// with several tokens holds the next byte until its last token transfers. Reset puts
// the scanner at the start of a source with line 1 and offset 0; src.ready is low while
// tokens of the current byte wait, except in the cycle its last token transfers.
module source_text_tokenizer (
	input  logic      clk,
	input  logic      arst_n,
	stt_in_if.sink    src,
	stt_out_if.source tok
);
	import stt_pkg::*;

	token_t [MAX_RES-1:0] toks;
	logic [2:0]           count;
	logic                 free;
	logic                 take;

	assign src.ready = free;
	assign take      = src.valid && free;

	stt_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.char_byte     (src.char_byte),
		.has_char      (src.has_char),
		.end_of_source (src.end_of_source),
		.toks          (toks),
		.count         (count)
	);

	stt_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.toks   (toks),
		.count  (count),
		.free   (free),
		.tok    (tok)
	);

endmodule

### test/source_text_tokenizer_tb.sv
// Self-checking source text tokenizer bench: directed, random sources, token predictor.
`timescale 1ns / 1ps

module source_text_tokenizer_tb;
	import stt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;

	typedef struct {
		logic [7:0] b;
		bit         has;
		bit         eos;
		bit         hold;
	} src_item_t;

	typedef struct {
		logic [5:0]  kind;
		logic [23:0] start;
		logic [23:0] span;
		logic [19:0] line;
		logic [7:0]  lit;
		logic [2:0]  err;
		logic        last;
	} token_rec_t;

	logic clk;
	logic arst_n;

	stt_in_if  src_ch ();
	stt_out_if tok_ch ();

	source_text_tokenizer dut (.clk(clk), .arst_n(arst_n), .src(src_ch), .tok(tok_ch));

	src_item_t  pending_items[$];
	token_rec_t want_tokens[$];
	src_item_t  nxt;
	token_rec_t got;
	token_rec_t exp_tok;

	int cycles;
	int errors;
	int bytes_sent;
	int sources;
	int tokens_checked;
	int hold_cnt;
	bit quiet;

	// scanner copy kept by the predictor
	scan_mode_t               lx_mode;
	logic [OFFSET_BITS-1:0]   lx_start;
	logic [OFFSET_BITS-1:0]   lx_off;
	logic [OFFSET_BITS-1:0]   lx_dot;
	logic [LINE_BITS-1:0]     lx_line;
	logic [7:0]               lx_prefix [KW_MAX_LEN];
	logic [3:0]               lx_wlen;
	logic [5:0]               lx_last;
	bit                       lx_seen;
	logic [7:0]               lx_pend;
	int                       run_count;

	string kw_names [KW_COUNT] = '{
		"ila", "numero", "doble", "letra", "tugoti", "balik", "samtang", "para",
		"kung", "kungdili", "kay", "buak", "padayon", "ug", "oh", "di", "tinuod",
		"peke", "sa", "buhata", "iprint", "xerox", "klase"
	};

	string frags [] = '{
		"ila", "numero", "doble", "letra", "tugoti", "balik", "samtang", "para",
		"kung", "kungdili", "kay", "buak", "padayon", "ug", "oh", "di", "tinuod",
		"peke", "sa", "buhata", "iprint", "xerox", "klase", "kungdilix", "x_1",
		"_Zq9", "abcdefghijk", "12", "1_000", "3.5", "7..9", "4.", "1.x", "2.5_1",
		"\"hi\"", "\"a\nb\"", "'a'", "'\\n'", "'\\t'", "'\\r'", "'\\\\'", "'\\''",
		"'\\0'", "'\\q'", "'ab'", "// note\n", "\n", "\n", " ", "\t", "\r", "(", ")",
		"{", "}", ":", ";", ",", "+=", "++", "+", "->", "-=", "--", "-", "*=", "*",
		"/=", "/", "==", "=", "..", ".", "@", "x\n"
	};

	string open_tails [] = '{"\"ab", "'", "'\\", "'x", "4.", "kung", "+", "//c", "."};

	function automatic bit lx_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit lx_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit lx_wordch(logic [7:0] c);
		return lx_alpha(c) || lx_digit(c) || c == CH_UNDER;
	endfunction

	function automatic bit semi_after(logic [5:0] k);
		return k == K_STRING || k == K_INT || k == K_CHAR || k == K_FLOAT || k == K_IDENT ||
			k == K_PLUS_PLUS || k == K_MINUS_MINUS || k == K_BUAK || k == K_PADAYON ||
			k == K_BALIK;
	endfunction

	function automatic logic [5:0] word_lookup();
		bit hit;
		if (lx_wlen > KW_MAX_LEN) return K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (kw_names[i].len() != lx_wlen) continue;
			hit = 1;
			for (int j = 0; j < lx_wlen; j++)
				if (kw_names[i][j] != lx_prefix[j]) hit = 0;
			if (hit) return 6'(i);
		end
		return K_IDENT;
	endfunction

	task automatic put_token(logic [5:0] k, logic [24:0] s, logic [24:0] e, logic [7:0] lit,
			logic [2:0] err);
		token_rec_t t;
		if (run_count >= MAX_RES) return;
		t.kind  = k;
		t.start = (s > OFFSET_MAX) ? OFFSET_MAX : s[23:0];
		t.span  = (e > s) ? (((e - s) > OFFSET_MAX) ? OFFSET_MAX : 24'(e - s)) : '0;
		t.line  = lx_line;
		t.lit   = lit;
		t.err   = err;
		t.last  = 0;
		want_tokens.push_back(t);
		run_count++;
		if (k != K_ERROR) begin
			lx_last = k;
			lx_seen = 1;
		end
	endtask

	task automatic lex_reset();
		lx_mode  = M_IDLE;
		lx_start = '0;
		lx_off   = '0;
		lx_dot   = '0;
		lx_line  = LINE_BITS'(1);
		lx_wlen  = '0;
		lx_last  = '0;
		lx_seen  = 0;
		lx_pend  = '0;
	endtask

	task automatic lex_idle(logic [7:0] c, logic [24:0] p);
		lx_start = p[23:0];
		lx_mode  = M_IDLE;
		case (c)
			"(": put_token(K_LPAREN, p, p + 1, 0, E_NONE);
			")": put_token(K_RPAREN, p, p + 1, 0, E_NONE);
			"{": put_token(K_LBRACE, p, p + 1, 0, E_NONE);
			"}": put_token(K_RBRACE, p, p + 1, 0, E_NONE);
			":": put_token(K_COLON, p, p + 1, 0, E_NONE);
			";": put_token(K_SEMI, p, p + 1, 0, E_NONE);
			",": put_token(K_COMMA, p, p + 1, 0, E_NONE);
			"+": lx_mode = M_PLUS;
			"-": lx_mode = M_MINUS;
			"*": lx_mode = M_STAR;
			"/": lx_mode = M_SLASH;
			"=": lx_mode = M_EQUAL;
			".": lx_mode = M_DOT;
			CH_DQUOTE: lx_mode = M_STRING;
			CH_SQUOTE: lx_mode = M_CHAR_OPEN;
			" ", CH_CR, CH_TAB: ;
			CH_NL: begin
				if (lx_line != LINE_MAX) lx_line++;
				if (lx_seen && semi_after(lx_last)) put_token(K_SEMI, p, p + 1, 0, E_NONE);
			end
			default: begin
				if (lx_digit(c)) begin
					lx_mode = M_NUMBER;
				end else if (lx_alpha(c) || c == CH_UNDER) begin
					lx_mode = M_IDENT;
					lx_prefix[0] = c;
					lx_wlen = 1;
				end else begin
					put_token(K_ERROR, p, p + 1, 0, E_UNEXPECTED);
				end
			end
		endcase
	endtask

	task automatic lex_byte(logic [7:0] c, logic [24:0] p);
		logic [24:0] s;
		bit again;
		bit bad;
		logic [7:0] v;
		s = lx_start;
		again = 0;
		bad = 0;
		v = 0;
		case (lx_mode)
			M_IDENT: begin
				if (lx_wordch(c)) begin
					if (lx_wlen < KW_MAX_LEN) lx_prefix[lx_wlen] = c;
					if (lx_wlen <= KW_MAX_LEN) lx_wlen++;
				end else begin
					put_token(word_lookup(), s, p, 0, E_NONE);
					again = 1;
				end
			end
			M_NUMBER: begin
				if (c == ".") begin
					lx_dot = p[23:0];
					lx_mode = M_NUM_DOT;
				end else if (!(lx_digit(c) || c == CH_UNDER)) begin
					put_token(K_INT, s, p, 0, E_NONE);
					again = 1;
				end
			end
			M_NUM_DOT: begin
				if (lx_digit(c)) begin
					lx_mode = M_FRACTION;
				end else begin
					put_token(K_INT, s, lx_dot, 0, E_NONE);
					if (c == ".") begin
						put_token(K_RANGE, lx_dot, p + 1, 0, E_NONE);
						lx_mode = M_IDLE;
					end else begin
						put_token(K_DOT, lx_dot, lx_dot + 1, 0, E_NONE);
						again = 1;
					end
				end
			end
			M_FRACTION: begin
				if (!(lx_digit(c) || c == CH_UNDER)) begin
					put_token(K_FLOAT, s, p, 0, E_NONE);
					again = 1;
				end
			end
			M_PLUS: begin
				if (c == "=") put_token(K_PLUS_EQ, s, p + 1, 0, E_NONE);
				else if (c == "+") put_token(K_PLUS_PLUS, s, p + 1, 0, E_NONE);
				else begin put_token(K_PLUS, s, s + 1, 0, E_NONE); again = 1; end
				lx_mode = M_IDLE;
			end
			M_MINUS: begin
				if (c == ">") put_token(K_ARROW, s, p + 1, 0, E_NONE);
				else if (c == "=") put_token(K_MINUS_EQ, s, p + 1, 0, E_NONE);
				else if (c == "-") put_token(K_MINUS_MINUS, s, p + 1, 0, E_NONE);
				else begin put_token(K_MINUS, s, s + 1, 0, E_NONE); again = 1; end
				lx_mode = M_IDLE;
			end
			M_STAR: begin
				if (c == "=") put_token(K_STAR_EQ, s, p + 1, 0, E_NONE);
				else begin put_token(K_STAR, s, s + 1, 0, E_NONE); again = 1; end
				lx_mode = M_IDLE;
			end
			M_SLASH: begin
				lx_mode = M_IDLE;
				if (c == "=") put_token(K_SLASH_EQ, s, p + 1, 0, E_NONE);
				else if (c == "/") lx_mode = M_COMMENT;
				else begin put_token(K_SLASH, s, s + 1, 0, E_NONE); again = 1; end
			end
			M_EQUAL: begin
				if (c == "=") put_token(K_EQ_EQ, s, p + 1, 0, E_NONE);
				else begin put_token(K_EQ, s, s + 1, 0, E_NONE); again = 1; end
				lx_mode = M_IDLE;
			end
			M_DOT: begin
				if (c == ".") put_token(K_RANGE, s, p + 1, 0, E_NONE);
				else begin put_token(K_DOT, s, s + 1, 0, E_NONE); again = 1; end
				lx_mode = M_IDLE;
			end
			M_COMMENT: if (c == CH_NL) again = 1;
			M_STRING: begin
				if (c == CH_DQUOTE) begin
					put_token(K_STRING, s, p + 1, 0, E_NONE);
					lx_mode = M_IDLE;
				end
			end
			M_CHAR_OPEN: begin
				if (c == CH_BSLASH) begin
					lx_mode = M_CHAR_ESC;
				end else begin
					lx_pend = c;
					lx_mode = M_CHAR_CLOSE;
				end
			end
			M_CHAR_ESC: begin
				case (c)
					"n": v = CH_NL;
					"t": v = CH_TAB;
					"r": v = CH_CR;
					CH_BSLASH: v = CH_BSLASH;
					CH_SQUOTE: v = CH_SQUOTE;
					"0": v = 8'h00;
					default: bad = 1;
				endcase
				if (bad) begin
					put_token(K_ERROR, s, p + 1, 0, E_BAD_ESC);
					lx_mode = M_IDLE;
				end else begin
					lx_pend = v;
					lx_mode = M_CHAR_CLOSE;
				end
			end
			M_CHAR_CLOSE: begin
				if (c == CH_SQUOTE) begin
					put_token(K_CHAR, s, p + 1, lx_pend, E_NONE);
					lx_mode = M_IDLE;
				end else begin
					put_token(K_ERROR, s, p, 0, E_NOT_SINGLE);
					again = 1;
				end
			end
			default: again = 1;
		endcase
		if (again) lex_idle(c, p);
	endtask

	task automatic lex_finish();
		logic [24:0] s;
		logic [24:0] e;
		s = lx_start;
		e = lx_off;
		case (lx_mode)
			M_IDENT: put_token(word_lookup(), s, e, 0, E_NONE);
			M_NUMBER: put_token(K_INT, s, e, 0, E_NONE);
			M_NUM_DOT: begin
				put_token(K_INT, s, lx_dot, 0, E_NONE);
				put_token(K_DOT, lx_dot, lx_dot + 1, 0, E_NONE);
			end
			M_FRACTION: put_token(K_FLOAT, s, e, 0, E_NONE);
			M_PLUS: put_token(K_PLUS, s, s + 1, 0, E_NONE);
			M_MINUS: put_token(K_MINUS, s, s + 1, 0, E_NONE);
			M_STAR: put_token(K_STAR, s, s + 1, 0, E_NONE);
			M_SLASH: put_token(K_SLASH, s, s + 1, 0, E_NONE);
			M_EQUAL: put_token(K_EQ, s, s + 1, 0, E_NONE);
			M_DOT: put_token(K_DOT, s, s + 1, 0, E_NONE);
			M_STRING: put_token(K_ERROR, s, e, 0, E_OPEN_STR);
			M_CHAR_OPEN: put_token(K_ERROR, s, e, 0, E_OPEN_CHAR);
			M_CHAR_ESC: put_token(K_ERROR, s, e, 0, E_OPEN_ESC);
			M_CHAR_CLOSE: put_token(K_ERROR, s, e, 0, E_NOT_SINGLE);
			default: ;
		endcase
		put_token(K_EOF, e, e, 0, E_NONE);
	endtask

	task automatic lex_item(logic [7:0] c, bit has, bit eos);
		run_count = 0;
		if (has) begin
			lex_byte(c, lx_off);
			if (lx_off != OFFSET_MAX) lx_off++;
		end
		if (eos) begin
			lex_finish();
			lex_reset();
		end
		if (run_count > 0) want_tokens[$].last = 1;
	endtask

	task automatic add_text(string s, bit hold);
		src_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.b = s[i];
			it.has = 1;
			it.eos = 0;
			it.hold = hold && i == 0;
			pending_items.push_back(it);
			bytes_sent++;
			// sprinkle empty items the block must ignore
			if ($urandom_range(99) < 4) begin
				it.b = 8'($urandom);
				it.has = 0;
				it.hold = 0;
				pending_items.push_back(it);
			end
		end
	endtask

	task automatic end_source(bit on_last);
		src_item_t it;
		sources++;
		if (on_last && pending_items.size() > 0 && pending_items[$].has) begin
			pending_items[$].eos = 1;
		end else begin
			it.b = 8'($urandom);
			it.has = 0;
			it.eos = 1;
			it.hold = 0;
			pending_items.push_back(it);
		end
	endtask

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > LIMIT_CYCLES) begin
				$display("source_text_tokenizer_tb: errors");
				$finish;
			end
		end
	end

	assign quiet = bytes_sent > 0 && pending_items.size() > 60 && pending_items.size() < 140;

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ch.valid         <= 1'b0;
			src_ch.char_byte     <= '0;
			src_ch.has_char      <= 1'b0;
			src_ch.end_of_source <= 1'b0;
		end else begin
			if (src_ch.valid && src_ch.ready)
				lex_item(src_ch.char_byte, src_ch.has_char, src_ch.end_of_source);
			if (!src_ch.valid || src_ch.ready) begin
				if (pending_items.size() == 0 ||
						(pending_items[0].hold && want_tokens.size() != 0) ||
						(!quiet && $urandom_range(99) < 16)) begin
					src_ch.valid <= 1'b0;
				end else begin
					nxt = pending_items.pop_front();
					src_ch.valid         <= 1'b1;
					src_ch.char_byte     <= nxt.b;
					src_ch.has_char      <= nxt.has;
					src_ch.end_of_source <= nxt.eos;
				end
			end
		end
	end

	// token side: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
			hold_cnt <= 0;
		end else begin
			if (cycles == 150) begin
				hold_cnt <= 120;
				tok_ch.ready <= 1'b0;
			end else begin
				if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
				tok_ch.ready <= hold_cnt <= 1 && (quiet || $urandom_range(99) >= 16);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			got.kind  = tok_ch.token_kind;
			got.start = tok_ch.start_offset;
			got.span  = tok_ch.span_length;
			got.line  = tok_ch.line_number;
			got.lit   = tok_ch.literal_char;
			got.err   = tok_ch.error_code;
			got.last  = tok_ch.last_of_run;
			if (want_tokens.size() == 0) begin
				$error("token with nothing expected: kind %0d at %0d", got.kind, got.start);
				errors++;
			end else begin
				exp_tok = want_tokens.pop_front();
				tokens_checked++;
				if (got.kind !== exp_tok.kind) begin
					$error("token_kind: expected %0d, got %0d", exp_tok.kind, got.kind);
					errors++;
				end
				if (got.start !== exp_tok.start) begin
					$error("start_offset: expected %0d, got %0d", exp_tok.start, got.start);
					errors++;
				end
				if (got.span !== exp_tok.span) begin
					$error("span_length: expected %0d, got %0d", exp_tok.span, got.span);
					errors++;
				end
				if (got.line !== exp_tok.line) begin
					$error("line_number: expected %0d, got %0d", exp_tok.line, got.line);
					errors++;
				end
				if (got.lit !== exp_tok.lit) begin
					$error("literal_char: expected %0d, got %0d", exp_tok.lit, got.lit);
					errors++;
				end
				if (got.err !== exp_tok.err) begin
					$error("error_code: expected %0d, got %0d", exp_tok.err, got.err);
					errors++;
				end
				if (got.last !== exp_tok.last) begin
					$error("last_of_run: expected %0d, got %0d", exp_tok.last, got.last);
					errors++;
				end
			end
		end
	end

	initial begin
		string s;
		int n;
		errors = 0;
		bytes_sent = 0;
		sources = 0;
		tokens_checked = 0;
		lex_reset();
		arst_n = 0;

		// directed: every operator, keyword boundaries, literal corner cases
		add_text("+=++ + ->-=-- - *=* /=/ ==.. . = (){}:;,\n", 0);
		end_source(1);
		add_text("kungdili kungdilix _a9 3.5 7..9 1.x\n", 1);
		end_source(0);
		add_text("'\\n''ab'\"x\"'\\q' // c\nbuak\n@", 0);
		end_source(1);
		add_text("'\\", 0);
		end_source(1);
		add_text("4.", 1);
		end_source(1);

		// random sources with mostly well-formed content
		while (bytes_sent < 330) begin
			n = $urandom_range(2, 14);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(99) < 10) begin
					s = " ";
					s[0] = 8'($urandom);
					if (s[0] == 8'h00) s = "\t";
					add_text(s, 0);
					// null and high bytes in literals take another path; add one directly
					if ($urandom_range(3) == 0) begin
						pending_items.push_back('{b: 8'($urandom), has: 1, eos: 0, hold: 0});
						bytes_sent++;
					end
				end else begin
					add_text(frags[$urandom_range(frags.size() - 1)], i == 0 && sources % 7 == 3);
				end
				if ($urandom_range(99) < 50) add_text(" ", 0);
			end
			if ($urandom_range(99) < 25) add_text(open_tails[$urandom_range(open_tails.size() - 1)], 0);
			end_source($urandom_range(1));
		end
		// bytes 0x00 and 0xFF reach both values of every bit
		pending_items.push_back('{b: 8'h00, has: 1, eos: 0, hold: 0});
		pending_items.push_back('{b: 8'hFF, has: 1, eos: 1, hold: 0});
		sources++;

		repeat (3) @(posedge clk);
		arst_n <= 1;

		while (pending_items.size() != 0 || src_ch.valid || want_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d sources, %0d bytes, %0d tokens checked", sources, bytes_sent,
			tokens_checked);
		if (errors == 0 && want_tokens.size() == 0) begin
			$display("source_text_tokenizer_tb: clean");
		end else begin
			$display("source_text_tokenizer_tb: errors");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/stt_pkg.sv
rtl/stt_in_if.sv
rtl/stt_out_if.sv
rtl/stt_scan.sv
rtl/stt_out.sv
rtl/source_text_tokenizer.sv
test/source_text_tokenizer_tb.sv
